FILE: hdl/gsam_pkg.sv
// ----------------------------------------------------------------------------
// Gyro spin angle monitor package
// Shared constants, codes and types for the spin angle monitor.
// ----------------------------------------------------------------------------
package gsam_pkg;

   // Rate format is signed Q(15-F).F deg/s
   localparam int RATE_FRAC_BITS = 6;

   // One degree = 2 * 2^F * 1e6 units = 2^DEG_SHIFT * DEG_ODD
   localparam int DEG_SHIFT = RATE_FRAC_BITS + 7;
   localparam int DEG_ODD   = 15625;

   // Accumulator and its magnitude
   localparam int ACC_W = 64;
   localparam int MAG_W = ACC_W - 1;
   localparam int SHW   = MAG_W - DEG_SHIFT;

   // Target magnitude times DEG_ODD stays below 2^29
   localparam int TGT_W = 15;
   localparam int TSC_W = 29;
   localparam logic [TSC_W-1:0] DEG_ODD_C = TSC_W'(DEG_ODD);

   // |acc| >> DEG_SHIFT at or above this saturates the degree output
   localparam logic [TSC_W-1:0] SAT_Q = TSC_W'(32768 * DEG_ODD);

   // floor(x / DEG_ODD) for x < 2^29 as (x * RECIP_MUL) >> RECIP_SHIFT
   localparam int RECIP_W     = 30;
   localparam int RECIP_SHIFT = 43;
   localparam logic [RECIP_W-1:0] RECIP_MUL = 30'd562949954;
   localparam int PROD_W      = TSC_W + RECIP_W;

   // Saturation limits of the accumulator, +/-(2^63 - 1)
   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-2){1'b0}}, 1'b1};

   // Configuration registers
   localparam int CSR_W     = 20;
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_INTERVAL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPIN_TIMEOUT = 1'b1;
   localparam logic [19:0] MIN_INTERVAL_RST = 20'd10000;
   localparam logic [15:0] SPIN_TIMEOUT_RST = 16'd10000;

   // Item kinds
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_POLL  = 1'b1;

   // Result events
   typedef enum logic [2:0] {
      EV_NONE  = 3'd0,
      EV_LEFT  = 3'd1,
      EV_RIGHT = 3'd2,
      EV_DONE  = 3'd3,
      EV_ABORT = 3'd4
   } event_type;

   // One request item
   typedef struct packed {
      logic               kind;
      logic signed [15:0] spin_angle;
      logic signed [15:0] gyro_rate;
      logic [31:0]        time_us;
      logic [31:0]        time_ms;
   } req_item_type;

   // Accumulator view handed to the decision logic
   typedef struct packed {
      logic               reached;
      logic signed [15:0] angle_deg;
   } acc_view_type;

endpackage

FILE: hdl/gsam_angle_conv.sv
// ----------------------------------------------------------------------------
// Accumulator to degrees converter
// Turns the accumulator into saturated whole degrees (toward zero) and
// compares its magnitude against the scaled target.
// ----------------------------------------------------------------------------
module gsam_angle_conv (
   input  logic signed [gsam_pkg::ACC_W-1:0] acc,
   input  logic [gsam_pkg::TSC_W-1:0]        target_scaled,
   output gsam_pkg::acc_view_type            view
);

   logic [gsam_pkg::ACC_W-1:0]  acc_neg;
   logic [gsam_pkg::MAG_W-1:0]  mag;
   logic [gsam_pkg::SHW-1:0]    mag_sh;
   logic                        sat;
   logic [gsam_pkg::PROD_W-1:0] prod;
   logic [15:0]                 quo;

   // Magnitude; the accumulator never reaches -2^63
   assign acc_neg = -acc;
   assign mag     = acc[gsam_pkg::ACC_W-1] ? acc_neg[gsam_pkg::MAG_W-1:0]
                                           : acc[gsam_pkg::MAG_W-1:0];

   // Drop the power-of-two part of the degree scale
   assign mag_sh = mag[gsam_pkg::MAG_W-1:gsam_pkg::DEG_SHIFT];

   assign sat = (mag_sh >= gsam_pkg::SHW'(gsam_pkg::SAT_Q));

   // Divide by the odd part through a reciprocal multiply, exact below 2^29
   assign prod = gsam_pkg::PROD_W'(mag_sh[gsam_pkg::TSC_W-1:0]) *
                 gsam_pkg::PROD_W'(gsam_pkg::RECIP_MUL);
   assign quo  = {1'b0, prod[gsam_pkg::RECIP_SHIFT +: 15]};

   // Target check and signed, saturated result
   always_comb begin
      view.reached = (mag_sh >= gsam_pkg::SHW'(target_scaled));
      if (sat) begin
         view.angle_deg = acc[gsam_pkg::ACC_W-1] ? 16'sh8000 : 16'sh7FFF;
      end else if (acc[gsam_pkg::ACC_W-1]) begin
         view.angle_deg = -quo;
      end else begin
         view.angle_deg = quo;
      end
   end

endmodule

FILE: hdl/gyro_spin_angle_monitor.sv
// ----------------------------------------------------------------------------
// Gyro spin angle monitor: trapezoidal gyro integration with turn tracking
// A request passes the input stage register, then the output register that
// holds its result; one item per cycle while the result side is not stalled,
// as the execute stage does the rate multiply and accumulator update at once.
// Synchronous reset disarms, clears state and loads both registers with 10000.
// ----------------------------------------------------------------------------
module gyro_spin_angle_monitor (
   input  logic                              clock,
   input  logic                              reset,
   // Configuration write port
   input  logic                              csr_wen,
   input  logic [gsam_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gsam_pkg::CSR_W-1:0]        csr_wdata,
   // Request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [15:0] spin_angle, [31:16] gyro_rate, [63:32] time_us, [95:64] time_ms
   input  logic [95:0]                       req_tdata,
   // [0] kind
   input  logic [0:0]                        req_tuser,
   // Result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [15:0] angle_deg
   output logic [15:0]                       rsp_tdata,
   // [2:0] event_res
   output logic [2:0]                        rsp_tuser
);

   // Configuration
   logic [19:0]                         min_interval_ff, min_interval_in;
   logic [15:0]                         spin_timeout_ff, spin_timeout_in;

   // Input stage
   logic                                in_valid_ff, in_valid_in;
   gsam_pkg::req_item_type              in_item_ff, in_item_in;
   gsam_pkg::req_item_type              req_item;

   // Spin state
   logic                                armed_ff, armed_in;
   logic [gsam_pkg::TSC_W-1:0]          tgt_scaled_ff, tgt_scaled_in;
   logic signed [gsam_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic signed [15:0]                  prev_rate_ff, prev_rate_in;
   logic [31:0]                         prev_time_us_ff, prev_time_us_in;
   logic [31:0]                         start_time_ms_ff, start_time_ms_in;

   // Output stage
   logic                                out_valid_ff, out_valid_in;
   gsam_pkg::event_type                 out_event_ff, out_event_in;
   logic signed [15:0]                  out_deg_ff, out_deg_in;

   // Handshake
   logic                                advance;
   logic                                exec_fire;
   logic                                in_fire;

   // Execute datapath
   gsam_pkg::acc_view_type              view;
   logic                                ang_neg;
   logic [16:0]                         ang_neg17;
   logic [15:0]                         ang_mag16;
   logic [gsam_pkg::TGT_W-1:0]          ang_mag;
   logic [gsam_pkg::TSC_W-1:0]          tgt_start;
   logic [31:0]                         dt_us;
   logic [31:0]                         el_ms;
   logic                                timed_out;
   logic                                interval_ok;
   logic signed [16:0]                  rate_sum;
   logic signed [49:0]                  inc;
   logic signed [gsam_pkg::ACC_W:0]     sum;
   logic                                pos_ovf;
   logic                                neg_ovf;
   logic signed [gsam_pkg::ACC_W-1:0]   acc_next;
   gsam_pkg::event_type                 ev;
   logic signed [15:0]                  deg;

   // Stream unpacking
   assign req_item.kind       = req_tuser[0];
   assign req_item.spin_angle = req_tdata[15:0];
   assign req_item.gyro_rate  = req_tdata[31:16];
   assign req_item.time_us    = req_tdata[63:32];
   assign req_item.time_ms    = req_tdata[95:64];

   // Stage control
   assign advance    = !out_valid_ff || rsp_tready;
   assign exec_fire  = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign in_fire    = req_tvalid && req_tready;

   // Register writes
   always_comb begin
      min_interval_in = min_interval_ff;
      spin_timeout_in = spin_timeout_ff;
      if (csr_wen) begin
         unique case (csr_index)
            gsam_pkg::CSR_MIN_INTERVAL: min_interval_in = csr_wdata;
            gsam_pkg::CSR_SPIN_TIMEOUT: spin_timeout_in = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Accumulator view: degrees and target reached
   gsam_angle_conv u_angle_conv (
      .acc           (acc_ff),
      .target_scaled (tgt_scaled_ff),
      .view          (view)
   );

   // Start: target magnitude, saturated for the most negative angle
   assign ang_neg   = in_item_ff.spin_angle[15];
   assign ang_neg17 = -{in_item_ff.spin_angle[15], in_item_ff.spin_angle};
   assign ang_mag16 = ang_neg ? ang_neg17[15:0] : in_item_ff.spin_angle;
   assign ang_mag   = ang_mag16[15] ? {gsam_pkg::TGT_W{1'b1}}
                                    : ang_mag16[gsam_pkg::TGT_W-1:0];
   assign tgt_start = gsam_pkg::TSC_W'(ang_mag) * gsam_pkg::DEG_ODD_C;

   // Poll: wrap-safe elapsed times
   assign dt_us       = in_item_ff.time_us - prev_time_us_ff;
   assign el_ms       = in_item_ff.time_ms - start_time_ms_ff;
   assign timed_out   = (el_ms > {16'd0, spin_timeout_ff});
   assign interval_ok = (dt_us >= {12'd0, min_interval_ff});

   // Trapezoid step and saturating add
   assign rate_sum = {prev_rate_ff[15], prev_rate_ff} +
                     {in_item_ff.gyro_rate[15], in_item_ff.gyro_rate};
   assign inc      = rate_sum * $signed({1'b0, dt_us});
   assign sum      = {acc_ff[gsam_pkg::ACC_W-1], acc_ff} + (gsam_pkg::ACC_W+1)'(inc);
   assign pos_ovf  = !sum[gsam_pkg::ACC_W] && sum[gsam_pkg::ACC_W-1];
   assign neg_ovf  = sum[gsam_pkg::ACC_W] &&
                     (!sum[gsam_pkg::ACC_W-1] || (sum[gsam_pkg::ACC_W-2:0] == '0));
   assign acc_next = pos_ovf ? gsam_pkg::ACC_MAX :
                     neg_ovf ? gsam_pkg::ACC_MIN : sum[gsam_pkg::ACC_W-1:0];

   // Decision for the item in the input stage
   always_comb begin
      armed_in         = armed_ff;
      tgt_scaled_in    = tgt_scaled_ff;
      acc_in           = acc_ff;
      prev_rate_in     = prev_rate_ff;
      prev_time_us_in  = prev_time_us_ff;
      start_time_ms_in = start_time_ms_ff;
      ev               = gsam_pkg::EV_NONE;
      deg              = '0;
      if (exec_fire) begin
         priority if (in_item_ff.kind == gsam_pkg::KIND_START) begin
            if (in_item_ff.spin_angle != '0) begin
               armed_in         = 1'b1;
               tgt_scaled_in    = tgt_start;
               acc_in           = '0;
               prev_rate_in     = in_item_ff.gyro_rate;
               prev_time_us_in  = in_item_ff.time_us;
               start_time_ms_in = in_item_ff.time_ms;
               ev = ang_neg ? gsam_pkg::EV_RIGHT : gsam_pkg::EV_LEFT;
            end else begin
               // zero angle completes at once
               armed_in      = 1'b0;
               tgt_scaled_in = '0;
               acc_in        = '0;
               ev            = gsam_pkg::EV_DONE;
            end
         end else if (armed_ff) begin
            priority if (view.reached) begin
               armed_in      = 1'b0;
               tgt_scaled_in = '0;
               acc_in        = '0;
               deg           = view.angle_deg;
               ev            = gsam_pkg::EV_DONE;
            end else if (timed_out) begin
               deg = view.angle_deg;
               ev  = gsam_pkg::EV_ABORT;
            end else if (interval_ok) begin
               acc_in          = acc_next;
               prev_rate_in    = in_item_ff.gyro_rate;
               prev_time_us_in = in_item_ff.time_us;
            end else begin
               // too soon after the last sample
               ev = gsam_pkg::EV_NONE;
            end
         end else begin
            // idle poll
            ev = gsam_pkg::EV_NONE;
         end
      end
   end

   // Stage loads
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_item_in   = in_item_ff;
      out_valid_in = out_valid_ff;
      out_event_in = out_event_ff;
      out_deg_in   = out_deg_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      if (in_fire) begin
         in_item_in = req_item;
      end
      if (advance) begin
         out_valid_in = in_valid_ff;
      end
      if (exec_fire) begin
         out_event_in = ev;
         out_deg_in   = deg;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_interval_ff  <= gsam_pkg::MIN_INTERVAL_RST;
         spin_timeout_ff  <= gsam_pkg::SPIN_TIMEOUT_RST;
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         armed_ff         <= 1'b0;
         tgt_scaled_ff    <= '0;
         acc_ff           <= '0;
         prev_rate_ff     <= '0;
         prev_time_us_ff  <= '0;
         start_time_ms_ff <= '0;
      end else begin
         min_interval_ff  <= min_interval_in;
         spin_timeout_ff  <= spin_timeout_in;
         in_valid_ff      <= in_valid_in;
         out_valid_ff     <= out_valid_in;
         armed_ff         <= armed_in;
         tgt_scaled_ff    <= tgt_scaled_in;
         acc_ff           <= acc_in;
         prev_rate_ff     <= prev_rate_in;
         prev_time_us_ff  <= prev_time_us_in;
         start_time_ms_ff <= start_time_ms_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_item_ff   <= in_item_in;
      out_event_ff <= out_event_in;
      out_deg_ff   <= out_deg_in;
   end

   // Result stream
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_deg_ff;
   assign rsp_tuser  = out_event_ff;

   // Disarming only happens with a completion result
   a_disarm_done : assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(armed_ff)) |->
         (out_valid_ff && (out_event_ff == gsam_pkg::EV_DONE)))
      else $error("disarm without completion result");

   // Idle state keeps a clear accumulator
   a_idle_acc_clear : assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !armed_ff) |-> (acc_ff == '0))
      else $error("accumulator not clear while idle");

   // A nonzero start reports a direction
   a_start_dir : assert property (@(posedge clock) disable iff (reset)
      (exec_fire && (in_item_ff.kind == gsam_pkg::KIND_START) &&
       (in_item_ff.spin_angle != '0)) |=>
         (rsp_tvalid && ((rsp_tuser == gsam_pkg::EV_LEFT) ||
                         (rsp_tuser == gsam_pkg::EV_RIGHT))))
      else $error("start without direction result");

   // Only completion and abort carry an angle
   a_quiet_angle : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && ((out_event_ff == gsam_pkg::EV_NONE) ||
                        (out_event_ff == gsam_pkg::EV_LEFT) ||
                        (out_event_ff == gsam_pkg::EV_RIGHT))) |->
         (out_deg_ff == '0))
      else $error("nonzero angle on a quiet result");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the gyro spin angle monitor
// A class tracks each spin: armed state, target, trapezoid sum and timers.
// It predicts one event per request transfer and checks every result
// against it in order. The run starts with a directed set of spins: zero
// angle, most negative angle, restart while armed, timeout boundary, both
// clock wraps and degree saturation. It then runs random spin sequences
// under several register settings, with random gaps on both streams and
// one long result hold-off that backs up the request side.
// ----------------------------------------------------------------------------
module tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 400;
   localparam longint DEG_UNITS =
      (64'sd2 << gsam_pkg::RATE_FRAC_BITS) * 64'sd1000000;
   localparam longint TURN_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;

   // Expected result: event and whole degrees
   typedef struct packed {
      gsam_pkg::event_type ev;
      logic signed [15:0]  deg;
   } spin_result_type;

   // Spin tracker: predicts the event of each request and checks results
   class spin_tracker;
      int unsigned min_interval;
      int unsigned timeout_ms;
      bit          armed;
      int unsigned target_deg;
      longint      turned;
      shortint     last_rate;
      int unsigned last_us;
      int unsigned start_ms;
      spin_result_type pending_events[$];
      int errors;
      int accepted;
      int checked;
      int seen[5];

      function new();
         min_interval = 32'(gsam_pkg::MIN_INTERVAL_RST);
         timeout_ms   = 32'(gsam_pkg::SPIN_TIMEOUT_RST);
         armed        = 1'b0;
         target_deg   = 0;
         turned       = 0;
         last_rate    = 0;
         last_us      = 0;
         start_ms     = 0;
         errors       = 0;
         accepted     = 0;
         checked      = 0;
         foreach (seen[i]) seen[i] = 0;
      endfunction

      function void write_reg(logic [gsam_pkg::CSR_IDX_W-1:0] idx,
                              logic [gsam_pkg::CSR_W-1:0] value);
         if (idx == gsam_pkg::CSR_MIN_INTERVAL) min_interval = 32'(value);
         else if (idx == gsam_pkg::CSR_SPIN_TIMEOUT) timeout_ms = 32'(value[15:0]);
      endfunction

      // Turned angle in whole degrees, truncated toward zero, saturated
      function logic signed [15:0] whole_degrees();
         longint d;
         d = turned / DEG_UNITS;
         if (d > 32767) d = 32767;
         if (d < -32768) d = -32768;
         return 16'(d);
      endfunction

      function void predict_request(gsam_pkg::req_item_type it);
         spin_result_type r;
         int          a;
         longint      mag;
         longint      step;
         int unsigned dt;
         int unsigned since;
         r.ev  = gsam_pkg::EV_NONE;
         r.deg = '0;
         accepted++;
         if (it.kind == gsam_pkg::KIND_START) begin
            a = int'(it.spin_angle);
            if (a != 0) begin
               target_deg = (a < 0) ? -a : a;
               if (target_deg > 32767) target_deg = 32767;
               turned    = 0;
               last_rate = it.gyro_rate;
               last_us   = it.time_us;
               start_ms  = it.time_ms;
               armed     = 1'b1;
               r.ev      = (a < 0) ? gsam_pkg::EV_RIGHT : gsam_pkg::EV_LEFT;
            end else begin
               armed      = 1'b0;
               turned     = 0;
               target_deg = 0;
               r.ev       = gsam_pkg::EV_DONE;
            end
         end else if (armed) begin
            mag   = (turned < 0) ? -turned : turned;
            dt    = it.time_us - last_us;
            since = it.time_ms - start_ms;
            if (mag >= longint'(target_deg) * DEG_UNITS) begin
               r.deg      = whole_degrees();
               r.ev       = gsam_pkg::EV_DONE;
               armed      = 1'b0;
               turned     = 0;
               target_deg = 0;
            end else if (since > timeout_ms) begin
               r.deg = whole_degrees();
               r.ev  = gsam_pkg::EV_ABORT;
            end else if (dt >= min_interval) begin
               // trapezoid (w0 + w1) * dt into a saturating sum
               step = (longint'(last_rate) + longint'(it.gyro_rate)) * longint'({32'd0, dt});
               if (step > 0 && turned > TURN_MAX - step) turned = TURN_MAX;
               else if (step < 0 && turned < -TURN_MAX - step) turned = -TURN_MAX;
               else turned += step;
               last_rate = it.gyro_rate;
               last_us   = it.time_us;
            end
         end
         pending_events.push_back(r);
      endfunction

      function void check_result(logic [2:0] ev, logic [15:0] deg);
         spin_result_type want;
         if (pending_events.size() == 0) begin
            $display("%0t: result with nothing expected: event %0d angle %0d",
                     $time, ev, $signed(deg));
            errors++;
            return;
         end
         want = pending_events.pop_front();
         checked++;
         seen[want.ev]++;
         if (ev !== want.ev) begin
            $display("%0t: event mismatch: expected %0d, actual %0d", $time, want.ev, ev);
            errors++;
         end
         if (deg !== want.deg) begin
            $display("%0t: angle mismatch: expected %0d, actual %0d",
                     $time, want.deg, $signed(deg));
            errors++;
         end
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           csr_wen;
   logic [gsam_pkg::CSR_IDX_W-1:0] csr_index;
   logic [gsam_pkg::CSR_W-1:0]     csr_wdata;
   logic                           req_tvalid;
   logic                           req_tready;
   // [15:0] spin_angle, [31:16] gyro_rate, [63:32] time_us, [95:64] time_ms
   logic [95:0]                    req_tdata;
   // [0] kind
   logic [0:0]                     req_tuser;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   // [15:0] angle_deg
   logic [15:0]                    rsp_tdata;
   // [2:0] event_res
   logic [2:0]                     rsp_tuser;

   spin_tracker            spin_chk;
   gsam_pkg::req_item_type seen_req;
   bit                     idle_on;
   bit                     hold_request;
   bit                     hold_done;
   int                     hold_left;
   int                     cycles;
   logic [31:0]            cur_us;
   logic [31:0]            cur_ms;

   gyro_spin_angle_monitor dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Request and result transfers go to the tracker
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         seen_req.kind       = req_tuser[0];
         seen_req.spin_angle = req_tdata[15:0];
         seen_req.gyro_rate  = req_tdata[31:16];
         seen_req.time_us    = req_tdata[63:32];
         seen_req.time_ms    = req_tdata[95:64];
         spin_chk.predict_request(seen_req);
      end
      if (!reset && rsp_tvalid && rsp_tready)
         spin_chk.check_result(rsp_tuser, rsp_tdata);
   end

   // Result side: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_request && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(99) < 16) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // One request transfer, with an occasional gap ahead of it
   task automatic send_req(input logic kind, input logic signed [15:0] angle,
                           input logic signed [15:0] rate, input logic [31:0] us,
                           input logic [31:0] ms);
      if (idle_on && $urandom_range(99) < 16) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ms, us, rate, angle};
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
   endtask

   // Wait until every expected result has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (spin_chk.pending_events.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [gsam_pkg::CSR_IDX_W-1:0] idx,
                            input logic [gsam_pkg::CSR_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
      spin_chk.write_reg(idx, value);
   endtask

   // Random spins: a start followed by polls with advancing clocks,
   // mixed with random noise items
   task automatic run_spins(input int count);
      int                 n;
      int                 polls;
      int unsigned        r;
      logic signed [15:0] ang;
      logic signed [15:0] rate;
      logic [31:0]        t0_ms;
      n = 0;
      while (n < count) begin
         if ($urandom_range(99) < 20) begin
            if ($urandom_range(1))
               send_req(1'($urandom_range(1)), 16'($urandom), 16'($urandom),
                        $urandom, $urandom);
            else
               send_req(gsam_pkg::KIND_POLL, 16'($urandom), 16'($urandom),
                        cur_us + $urandom_range(20000), cur_ms + $urandom_range(5));
            n++;
         end else begin
            case ($urandom_range(11))
               0:       ang = 16'sh8000;
               1:       ang = 16'sh7FFF;
               2:       ang = 16'sd0;
               default: ang = 16'($urandom_range(1, 270));
            endcase
            if ($urandom_range(1)) ang = -ang;
            rate  = 16'($urandom);
            t0_ms = cur_ms;
            send_req(gsam_pkg::KIND_START, ang, rate, cur_us, cur_ms);
            polls = $urandom_range(1, 25);
            n += 1 + polls;
            repeat (polls) begin
               r = $urandom_range(99);
               if (r < 12 && spin_chk.min_interval > 0)
                  cur_us += $urandom_range(spin_chk.min_interval - 1);
               else if (r < 16)
                  cur_us += $urandom;
               else
                  cur_us += spin_chk.min_interval + $urandom_range(60000);
               r = $urandom_range(99);
               if (r < 8)
                  cur_ms += spin_chk.timeout_ms + 1 + $urandom_range(100);
               else if (r < 11)
                  cur_ms = t0_ms + spin_chk.timeout_ms;
               else
                  cur_ms += $urandom_range(30);
               if ($urandom_range(99) < 15) begin
                  rate = 16'($urandom);
               end else begin
                  rate = 16'($urandom_range(4000, 32767));
                  if (ang < 0) rate = -rate;
               end
               send_req(gsam_pkg::KIND_POLL, 16'($urandom), rate, cur_us, cur_ms);
            end
         end
      end
   endtask

   initial begin
      spin_chk     = new();
      reset        = 1'b1;
      csr_wen      = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      idle_on      = 1'b1;
      hold_request = 1'b0;
      hold_done    = 1'b0;
      hold_left    = 0;
      cycles       = 0;
      cur_us       = $urandom;
      cur_ms       = $urandom;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed spins under reset register values
      send_req(gsam_pkg::KIND_POLL, 16'sd0, 16'sh7FFF, 32'hFFFF_FFFF, 32'h0); // idle poll
      send_req(gsam_pkg::KIND_START, 16'sd0, 16'sd0, 32'd0, 32'd0);          // zero angle
      // one degree left at full rate, a too-early poll, then done at 5
      send_req(gsam_pkg::KIND_START, 16'sd1, 16'sh7FFF, 32'd1000, 32'd500);
      send_req(gsam_pkg::KIND_POLL, 16'sd0, 16'sh7FFF, 32'd10999, 32'd500);
      send_req(gsam_pkg::KIND_POLL, 16'sd0, 16'sh7FFF, 32'd11000, 32'd500);
      send_req(gsam_pkg::KIND_POLL, 16'sd0, 16'sh7FFF, 32'd11001, 32'd500);
      // most negative angle, ms clock wraps, timeout boundary then abort
      send_req(gsam_pkg::KIND_START, 16'sh8000, 16'sh8000, 32'd0, 32'hFFFF_FFF0);
      send_req(gsam_pkg::KIND_POLL, 16'sd0, 16'sh8000, 32'd20000, 32'd5);
      send_req(gsam_pkg::KIND_POLL, 16'sd0, 16'sh8000, 32'd20000, 32'd9984);
      send_req(gsam_pkg::KIND_POLL, 16'sd0, 16'sh8000, 32'd20000, 32'd9985);
      send_req(gsam_pkg::KIND_POLL, 16'sd0, 16'sh8000, 32'd20000, 32'hFFFF_FFFF);
      // restart while armed, us clock wraps, huge step saturates degrees
      send_req(gsam_pkg::KIND_START, 16'sd100, 16'sh7FFF, 32'hFFFF_FF00, 32'd0);
      send_req(gsam_pkg::KIND_POLL, 16'sd0, 16'sh7FFF, 32'h8000_0000, 32'd0);
      send_req(gsam_pkg::KIND_POLL, 16'sd0, 16'sh7FFF, 32'h8000_0000, 32'd0);
      send_req(gsam_pkg::KIND_START, -16'sd100, 16'sh8000, 32'd0, 32'd0);
      send_req(gsam_pkg::KIND_POLL, 16'sd0, 16'sh8000, 32'hFFFF_FFFF, 32'd0);
      send_req(gsam_pkg::KIND_POLL, 16'sd0, 16'sh8000, 32'hFFFF_FFFF, 32'd0);
      // small right turn completes with a negative angle
      send_req(gsam_pkg::KIND_START, -16'sd2, -16'sd20000, 32'd100, 32'd100);
      send_req(gsam_pkg::KIND_POLL, 16'sd0, 16'sh8000, 32'd10100, 32'd100);
      send_req(gsam_pkg::KIND_POLL, 16'sd0, 16'sh8000, 32'd10100, 32'd100);
      // full left target, no motion, abort, then a zero start disarms
      send_req(gsam_pkg::KIND_START, 16'sh7FFF, 16'sd0, 32'd0, 32'd0);
      send_req(gsam_pkg::KIND_POLL, 16'sh7FFF, 16'sd0, 32'd10000, 32'd0);
      send_req(gsam_pkg::KIND_POLL, 16'sd0, 16'sd0, 32'd10000, 32'd10001);
      send_req(gsam_pkg::KIND_START, 16'sd0, 16'sd0, 32'd0, 32'd0);
      send_req(gsam_pkg::KIND_POLL, 16'sd0, 16'sh7FFF, 32'd50000, 32'd50000);

      // Random spins under reset values, with the long result hold-off
      hold_request = 1'b1;
      run_spins(250);
      drain();

      // No interval, longest timeout, no idling on either side
      write_reg(gsam_pkg::CSR_MIN_INTERVAL, 20'd0);
      write_reg(gsam_pkg::CSR_SPIN_TIMEOUT, 20'd65535);
      idle_on = 1'b0;
      run_spins(300);
      drain();

      // Widest interval; timeout written with upper bits set, so zero
      idle_on = 1'b1;
      write_reg(gsam_pkg::CSR_MIN_INTERVAL, 20'hFFFFF);
      write_reg(gsam_pkg::CSR_SPIN_TIMEOUT, 20'hF_0000);
      run_spins(200);
      drain();

      write_reg(gsam_pkg::CSR_MIN_INTERVAL, 20'($urandom_range(1, 200000)));
      write_reg(gsam_pkg::CSR_SPIN_TIMEOUT, 20'($urandom_range(1, 65535)));
      run_spins(300);
      drain();

      write_reg(gsam_pkg::CSR_MIN_INTERVAL, 20'd1000);
      write_reg(gsam_pkg::CSR_SPIN_TIMEOUT, 20'hA_0001);
      run_spins(300);
      drain();
      repeat (6) @(posedge clock);

      $display("tb: %0d requests, %0d results checked, %0d errors", spin_chk.accepted,
               spin_chk.checked, spin_chk.errors);
      $display("tb: none %0d, left %0d, right %0d, complete %0d, abort %0d",
               spin_chk.seen[gsam_pkg::EV_NONE], spin_chk.seen[gsam_pkg::EV_LEFT],
               spin_chk.seen[gsam_pkg::EV_RIGHT], spin_chk.seen[gsam_pkg::EV_DONE],
               spin_chk.seen[gsam_pkg::EV_ABORT]);
      if (spin_chk.errors == 0 && spin_chk.pending_events.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
